>>> design/gmmgs_pkg.sv
// Package for the grid maze map greedy step block.
// Holds the widths, codes and record types shared by the map memory,
// the geometry unit and the top level. Depends on nothing.
package gmmgs_pkg;

  localparam int GRID_MAX   = 16;
  localparam int COORD_W    = 4;
  localparam int CELLS      = GRID_MAX * GRID_MAX;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int SIZE_W     = 5;
  localparam int COST_W     = 10;
  localparam int COST_LIMIT = 1000;
  localparam int D2_W       = 2 * COORD_W + 1;
  localparam int BOUND_W    = 2 * COST_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [COST_W-1:0]  COST_MAX      = '1;
  localparam logic [SIZE_W-1:0]  GRID_SIZE_RST = 5'd9;
  localparam logic [COORD_W-1:0] GOAL_ROW_RST  = 4'd4;
  localparam logic [COORD_W-1:0] GOAL_COL_RST  = 4'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 2'd2;

  typedef enum logic [1:0] {
    ACT_SENSE   = 2'd0,
    ACT_FORCE   = 2'd1,
    ACT_SOLVE   = 2'd2,
    ACT_REBUILD = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef struct packed {
    logic              wall_n;
    logic              wall_e;
    logic              closed;
    logic [COST_W-1:0] cost;
  } map_word_t;

  typedef struct packed {
    logic               in_grid;
    logic               edge_ok;
    logic               own_north;
    logic [CELL_W-1:0]  owner_idx;
    logic [CELL_W-1:0]  cur_idx;
    logic [CELL_W-1:0]  nbr_idx;
    logic [COORD_W-1:0] nbr_row;
    logic [COORD_W-1:0] nbr_col;
    logic [D2_W-1:0]    d2;
  } geom_t;

endpackage

>>> design/grid_maze_map_greedy_step.sv
// Top level of the grid maze map greedy step block: sequencer, item and
// configuration registers. Uses gmmgs_pkg, gmmgs_map_mem and gmmgs_geom_unit.
//
// Channel  Ports                               Transfer
// input    start, busy, in_*                   start high while busy is low
// result   out_strobe, out_*                   out_strobe high for one cycle
// config   cfg_valid, cfg_ready, cfg_index,    cfg_valid and cfg_ready high
//          cfg_data
//
// The strobe ends each action: rebuild clears the map, sense and force read and
// write edges, solve scans the neighbors; all map accesses share the one map memory.
// busy falls as the strobe rises, so the next item can transfer in that cycle.
// Reset restores the register defaults and clears the map valid bits.
// The result receiver cannot stall, and cfg_ready is always high.
module grid_maze_map_greedy_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_action,
  input  logic [gmmgs_pkg::COORD_W-1:0]       in_cell_row,
  input  logic [gmmgs_pkg::COORD_W-1:0]       in_cell_col,
  input  logic [1:0]                          in_heading,
  input  logic                                in_wall_ahead,
  input  logic                                in_far_wall_left,
  input  logic                                in_far_wall_front,
  input  logic                                in_far_wall_right,
  output logic                                out_strobe,
  output logic                                out_map_changed,
  output logic                                out_found,
  output logic [gmmgs_pkg::COORD_W-1:0]       out_next_row,
  output logic [gmmgs_pkg::COORD_W-1:0]       out_next_col,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmmgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gmmgs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE        = 11'b000_0000_0001,
    ST_SENSE_NB    = 11'b000_0000_0010,
    ST_EDGE_RD     = 11'b000_0000_0100,
    ST_EDGE_WR     = 11'b000_0000_1000,
    ST_SOLVE_CUR   = 11'b000_0001_0000,
    ST_SOLVE_G     = 11'b000_0010_0000,
    ST_SOLVE_BOUND = 11'b000_0100_0000,
    ST_NB_RD       = 11'b000_1000_0000,
    ST_NB_CHK      = 11'b001_0000_0000,
    ST_SOLVE_MARK  = 11'b010_0000_0000,
    ST_CLEAR       = 11'b100_0000_0000
  } state_t;

  function automatic gmmgs_pkg::dir_t solve_dir(input logic [1:0] k);
    gmmgs_pkg::dir_t d;
    unique case (k)
      2'd0:    d = gmmgs_pkg::DIR_S;
      2'd1:    d = gmmgs_pkg::DIR_W;
      2'd2:    d = gmmgs_pkg::DIR_E;
      default: d = gmmgs_pkg::DIR_N;
    endcase
    return d;
  endfunction

  state_t state_r, state_nxt;
  logic [gmmgs_pkg::SIZE_W-1:0]  size_r;
  logic [gmmgs_pkg::COORD_W-1:0] goal_row_r;
  logic [gmmgs_pkg::COORD_W-1:0] goal_col_r;
  logic                          out_valid_r, out_valid_nxt;

  gmmgs_pkg::action_t            act_r, act_nxt;
  gmmgs_pkg::dir_t               head_r, head_nxt;
  logic                          ahead_r, ahead_nxt;
  logic [2:0]                    far_r, far_nxt;
  logic [gmmgs_pkg::COORD_W-1:0] base_row_r, base_row_nxt;
  logic [gmmgs_pkg::COORD_W-1:0] base_col_r, base_col_nxt;
  logic [1:0]                    k_r, k_nxt;
  logic [2:0]                    mask_r, mask_nxt;
  logic                          changed_r, changed_nxt;
  logic [gmmgs_pkg::COST_W-1:0]  g_r, g_nxt;
  logic                          cur_wn_r, cur_wn_nxt;
  logic                          cur_we_r, cur_we_nxt;
  logic                          usable_r, usable_nxt;
  logic [gmmgs_pkg::BOUND_W-1:0] bound_r, bound_nxt;
  logic                          have_r, have_nxt;
  logic [gmmgs_pkg::D2_W-1:0]    best_d2_r, best_d2_nxt;
  logic [gmmgs_pkg::COORD_W-1:0] best_row_r, best_row_nxt;
  logic [gmmgs_pkg::COORD_W-1:0] best_col_r, best_col_nxt;
  logic [gmmgs_pkg::CELL_W-1:0]  best_idx_r, best_idx_nxt;
  logic                          best_wn_r, best_wn_nxt;
  logic                          best_we_r, best_we_nxt;
  logic                          out_changed_r, out_changed_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [gmmgs_pkg::COORD_W-1:0] out_row_r, out_row_nxt;
  logic [gmmgs_pkg::COORD_W-1:0] out_col_r, out_col_nxt;

  gmmgs_pkg::dir_t               geo_dir;
  gmmgs_pkg::geom_t              geo;
  gmmgs_pkg::map_word_t          mem_rd_data;
  gmmgs_pkg::map_word_t          mem_wr_data;
  logic [gmmgs_pkg::CELL_W-1:0]  mem_rd_addr;
  logic [gmmgs_pkg::CELL_W-1:0]  mem_wr_addr;
  logic                          mem_wr_en;
  logic                          mem_clear;

  gmmgs_map_mem u_map_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (mem_clear),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  gmmgs_geom_unit u_geom_unit (
    .grid_size (size_r),
    .goal_row  (goal_row_r),
    .goal_col  (goal_col_r),
    .row       (base_row_r),
    .col       (base_col_r),
    .dir       (geo_dir),
    .geo       (geo)
  );

  always_comb begin
    if (act_r == gmmgs_pkg::ACT_SOLVE) begin
      geo_dir = solve_dir(k_r);
    end else if (state_r == ST_SENSE_NB) begin
      geo_dir = head_r;
    end else begin
      geo_dir = gmmgs_pkg::dir_t'(head_r + k_r + 2'd3);
    end
  end

  always_comb begin
    logic                          done;
    logic                          res_changed;
    logic                          res_found;
    logic [gmmgs_pkg::COORD_W-1:0] res_row;
    logic [gmmgs_pkg::COORD_W-1:0] res_col;
    logic                          old_bit;
    logic                          new_bit;
    logic                          open_edge;
    logic                          pick;
    logic [gmmgs_pkg::COST_W-1:0]  diff;
    gmmgs_pkg::map_word_t          word;

    done        = 1'b0;
    res_changed = 1'b0;
    res_found   = 1'b0;
    res_row     = '0;
    res_col     = '0;
    old_bit     = 1'b0;
    new_bit     = 1'b0;
    open_edge   = 1'b0;
    pick        = 1'b0;
    diff        = '0;
    word        = mem_rd_data;

    state_nxt    = state_r;
    out_valid_nxt = 1'b0;
    act_nxt      = act_r;
    head_nxt     = head_r;
    ahead_nxt    = ahead_r;
    far_nxt      = far_r;
    base_row_nxt = base_row_r;
    base_col_nxt = base_col_r;
    k_nxt        = k_r;
    mask_nxt     = mask_r;
    changed_nxt  = changed_r;
    g_nxt        = g_r;
    cur_wn_nxt   = cur_wn_r;
    cur_we_nxt   = cur_we_r;
    usable_nxt   = usable_r;
    bound_nxt    = bound_r;
    have_nxt     = have_r;
    best_d2_nxt  = best_d2_r;
    best_row_nxt = best_row_r;
    best_col_nxt = best_col_r;
    best_idx_nxt = best_idx_r;
    best_wn_nxt  = best_wn_r;
    best_we_nxt  = best_we_r;

    mem_rd_addr = geo.owner_idx;
    mem_wr_addr = geo.owner_idx;
    mem_wr_data = mem_rd_data;
    mem_wr_en   = 1'b0;
    mem_clear   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt      = gmmgs_pkg::action_t'(in_action);
          head_nxt     = gmmgs_pkg::dir_t'(in_heading);
          ahead_nxt    = in_wall_ahead;
          far_nxt      = {in_far_wall_right, in_far_wall_front, in_far_wall_left};
          base_row_nxt = in_cell_row;
          base_col_nxt = in_cell_col;
          k_nxt        = 2'd0;
          mask_nxt     = 3'b010;
          changed_nxt  = 1'b0;
          unique case (gmmgs_pkg::action_t'(in_action))
            gmmgs_pkg::ACT_SENSE: begin
              state_nxt = in_wall_ahead ? ST_EDGE_RD : ST_SENSE_NB;
            end
            gmmgs_pkg::ACT_FORCE:   state_nxt = ST_EDGE_RD;
            gmmgs_pkg::ACT_SOLVE:   state_nxt = ST_SOLVE_CUR;
            gmmgs_pkg::ACT_REBUILD: state_nxt = ST_CLEAR;
            default:                state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SENSE_NB: begin
        if (geo.edge_ok) begin
          base_row_nxt = geo.nbr_row;
          base_col_nxt = geo.nbr_col;
          mask_nxt     = far_r;
          state_nxt    = ST_EDGE_RD;
        end else begin
          done = 1'b1;
        end
      end

      ST_EDGE_RD: begin
        if (mask_r[k_r] && geo.edge_ok) begin
          state_nxt = ST_EDGE_WR;
        end else if (k_r == 2'd2) begin
          done        = 1'b1;
          res_changed = changed_r;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end

      ST_EDGE_WR: begin
        old_bit = geo.own_north ? mem_rd_data.wall_n : mem_rd_data.wall_e;
        new_bit = (act_r == gmmgs_pkg::ACT_FORCE) ? ahead_r : 1'b1;
        if (geo.own_north) begin
          word.wall_n = new_bit;
        end else begin
          word.wall_e = new_bit;
        end
        mem_wr_en   = 1'b1;
        mem_wr_data = word;
        if ((act_r == gmmgs_pkg::ACT_SENSE) && !old_bit) begin
          changed_nxt = 1'b1;
        end
        if (k_r == 2'd2) begin
          done        = 1'b1;
          res_changed = changed_nxt;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_EDGE_RD;
        end
      end

      ST_SOLVE_CUR: begin
        mem_rd_addr = geo.cur_idx;
        if (geo.in_grid) begin
          state_nxt = ST_SOLVE_G;
        end else begin
          done = 1'b1;
        end
      end

      ST_SOLVE_G: begin
        g_nxt      = (mem_rd_data.cost == gmmgs_pkg::COST_MAX) ? gmmgs_pkg::COST_MAX
                   : mem_rd_data.cost + 1'b1;
        cur_wn_nxt = mem_rd_data.wall_n;
        cur_we_nxt = mem_rd_data.wall_e;
        state_nxt  = ST_SOLVE_BOUND;
      end

      ST_SOLVE_BOUND: begin
        usable_nxt = g_r < gmmgs_pkg::COST_W'(gmmgs_pkg::COST_LIMIT);
        diff       = gmmgs_pkg::COST_W'(gmmgs_pkg::COST_LIMIT) - g_r;
        bound_nxt  = gmmgs_pkg::BOUND_W'(diff) * gmmgs_pkg::BOUND_W'(diff);
        have_nxt   = 1'b0;
        k_nxt      = 2'd0;
        state_nxt  = ST_NB_RD;
      end

      ST_NB_RD: begin
        mem_rd_addr = geo.nbr_idx;
        if (geo.edge_ok) begin
          state_nxt = ST_NB_CHK;
        end else if (k_r == 2'd3) begin
          state_nxt = ST_SOLVE_MARK;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end

      ST_NB_CHK: begin
        unique case (geo_dir)
          gmmgs_pkg::DIR_N: open_edge = !cur_wn_r;
          gmmgs_pkg::DIR_E: open_edge = !cur_we_r;
          gmmgs_pkg::DIR_S: open_edge = !mem_rd_data.wall_n;
          gmmgs_pkg::DIR_W: open_edge = !mem_rd_data.wall_e;
          default:          open_edge = 1'b0;
        endcase
        word.cost   = g_r;
        mem_wr_addr = geo.nbr_idx;
        mem_wr_data = word;
        mem_wr_en   = open_edge;
        pick = open_edge && !mem_rd_data.closed && usable_r
            && (gmmgs_pkg::BOUND_W'(geo.d2) < bound_r)
            && (!have_r || (geo.d2 < best_d2_r));
        if (pick) begin
          have_nxt     = 1'b1;
          best_d2_nxt  = geo.d2;
          best_row_nxt = geo.nbr_row;
          best_col_nxt = geo.nbr_col;
          best_idx_nxt = geo.nbr_idx;
          best_wn_nxt  = mem_rd_data.wall_n;
          best_we_nxt  = mem_rd_data.wall_e;
        end
        if (k_r == 2'd3) begin
          state_nxt = ST_SOLVE_MARK;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_NB_RD;
        end
      end

      ST_SOLVE_MARK: begin
        mem_wr_addr = best_idx_r;
        mem_wr_data = '{wall_n: best_wn_r, wall_e: best_we_r, closed: 1'b1, cost: g_r};
        mem_wr_en   = have_r;
        done        = 1'b1;
        res_found   = have_r;
        res_row     = have_r ? best_row_r : '0;
        res_col     = have_r ? best_col_r : '0;
      end

      ST_CLEAR: begin
        mem_clear = 1'b1;
        done      = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
    end

    out_changed_nxt = done ? res_changed : out_changed_r;
    out_found_nxt   = done ? res_found   : out_found_r;
    out_row_nxt     = done ? res_row     : out_row_r;
    out_col_nxt     = done ? res_col     : out_col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      size_r      <= gmmgs_pkg::GRID_SIZE_RST;
      goal_row_r  <= gmmgs_pkg::GOAL_ROW_RST;
      goal_col_r  <= gmmgs_pkg::GOAL_COL_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gmmgs_pkg::CFG_GRID_SIZE: size_r     <= cfg_data;
          gmmgs_pkg::CFG_GOAL_ROW:  goal_row_r <= cfg_data[gmmgs_pkg::COORD_W-1:0];
          gmmgs_pkg::CFG_GOAL_COL:  goal_col_r <= cfg_data[gmmgs_pkg::COORD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    head_r        <= head_nxt;
    ahead_r       <= ahead_nxt;
    far_r         <= far_nxt;
    base_row_r    <= base_row_nxt;
    base_col_r    <= base_col_nxt;
    k_r           <= k_nxt;
    mask_r        <= mask_nxt;
    changed_r     <= changed_nxt;
    g_r           <= g_nxt;
    cur_wn_r      <= cur_wn_nxt;
    cur_we_r      <= cur_we_nxt;
    usable_r      <= usable_nxt;
    bound_r       <= bound_nxt;
    have_r        <= have_nxt;
    best_d2_r     <= best_d2_nxt;
    best_row_r    <= best_row_nxt;
    best_col_r    <= best_col_nxt;
    best_idx_r    <= best_idx_nxt;
    best_wn_r     <= best_wn_nxt;
    best_we_r     <= best_we_nxt;
    out_changed_r <= out_changed_nxt;
    out_found_r   <= out_found_nxt;
    out_row_r     <= out_row_nxt;
    out_col_r     <= out_col_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_strobe      = out_valid_r;
  assign out_map_changed = out_changed_r;
  assign out_found       = out_found_r;
  assign out_next_row    = out_row_r;
  assign out_next_col    = out_col_r;

endmodule

>>> design/gmmgs_map_mem.sv
// Map memory: one word per cell with both wall bits, closed mark and cost.
// Registered read, single write port, per-entry valid bits cleared at once.
// Depends on gmmgs_pkg.
module gmmgs_map_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic [gmmgs_pkg::CELL_W-1:0] rd_addr,
  output gmmgs_pkg::map_word_t      rd_data,
  input  logic                      wr_en,
  input  logic [gmmgs_pkg::CELL_W-1:0] wr_addr,
  input  gmmgs_pkg::map_word_t      wr_data
);

  gmmgs_pkg::map_word_t mem_r [gmmgs_pkg::CELLS];
  gmmgs_pkg::map_word_t rd_word_r;
  logic [gmmgs_pkg::CELLS-1:0] vld_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_word_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (clear) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

>>> design/gmmgs_geom_unit.sv
// Shared geometry unit: for a cell and a direction it finds the edge owner,
// the neighbor and the neighbor's squared distance to the goal.
// Depends on gmmgs_pkg.
module gmmgs_geom_unit (
  input  logic [gmmgs_pkg::SIZE_W-1:0]  grid_size,
  input  logic [gmmgs_pkg::COORD_W-1:0] goal_row,
  input  logic [gmmgs_pkg::COORD_W-1:0] goal_col,
  input  logic [gmmgs_pkg::COORD_W-1:0] row,
  input  logic [gmmgs_pkg::COORD_W-1:0] col,
  input  gmmgs_pkg::dir_t               dir,
  output gmmgs_pkg::geom_t              geo
);

  always_comb begin
    logic [gmmgs_pkg::SIZE_W-1:0]  size_used;
    logic [gmmgs_pkg::SIZE_W-1:0]  row_x;
    logic [gmmgs_pkg::SIZE_W-1:0]  col_x;
    logic                          exists;
    logic                          in_grid;
    logic                          own_north;
    logic [gmmgs_pkg::COORD_W-1:0] own_row;
    logic [gmmgs_pkg::COORD_W-1:0] own_col;
    logic [gmmgs_pkg::COORD_W-1:0] nbr_row;
    logic [gmmgs_pkg::COORD_W-1:0] nbr_col;
    logic [gmmgs_pkg::COORD_W-1:0] dr;
    logic [gmmgs_pkg::COORD_W-1:0] dc;

    priority if (grid_size < gmmgs_pkg::SIZE_W'(2)) begin
      size_used = gmmgs_pkg::SIZE_W'(2);
    end else if (grid_size > gmmgs_pkg::SIZE_W'(gmmgs_pkg::GRID_MAX)) begin
      size_used = gmmgs_pkg::SIZE_W'(gmmgs_pkg::GRID_MAX);
    end else begin
      size_used = grid_size;
    end

    row_x   = gmmgs_pkg::SIZE_W'(row);
    col_x   = gmmgs_pkg::SIZE_W'(col);
    in_grid = (row_x < size_used) && (col_x < size_used);

    unique case (dir)
      gmmgs_pkg::DIR_N: begin
        exists    = (row_x + gmmgs_pkg::SIZE_W'(1)) < size_used;
        own_north = 1'b1;
        own_row   = row;
        own_col   = col;
        nbr_row   = row + 1'b1;
        nbr_col   = col;
      end
      gmmgs_pkg::DIR_E: begin
        exists    = (col_x + gmmgs_pkg::SIZE_W'(1)) < size_used;
        own_north = 1'b0;
        own_row   = row;
        own_col   = col;
        nbr_row   = row;
        nbr_col   = col + 1'b1;
      end
      gmmgs_pkg::DIR_S: begin
        exists    = (row != '0);
        own_north = 1'b1;
        own_row   = row - 1'b1;
        own_col   = col;
        nbr_row   = row - 1'b1;
        nbr_col   = col;
      end
      gmmgs_pkg::DIR_W: begin
        exists    = (col != '0);
        own_north = 1'b0;
        own_row   = row;
        own_col   = col - 1'b1;
        nbr_row   = row;
        nbr_col   = col - 1'b1;
      end
      default: begin
        exists    = 1'b0;
        own_north = 1'b0;
        own_row   = row;
        own_col   = col;
        nbr_row   = row;
        nbr_col   = col;
      end
    endcase

    dr = (nbr_row >= goal_row) ? (nbr_row - goal_row) : (goal_row - nbr_row);
    dc = (nbr_col >= goal_col) ? (nbr_col - goal_col) : (goal_col - nbr_col);

    geo.in_grid   = in_grid;
    geo.edge_ok   = in_grid && exists;
    geo.own_north = own_north;
    geo.owner_idx = {own_row, own_col};
    geo.cur_idx   = {row, col};
    geo.nbr_idx   = {nbr_row, nbr_col};
    geo.nbr_row   = nbr_row;
    geo.nbr_col   = nbr_col;
    geo.d2        = gmmgs_pkg::D2_W'(dr) * gmmgs_pkg::D2_W'(dr)
                  + gmmgs_pkg::D2_W'(dc) * gmmgs_pkg::D2_W'(dc);
  end

endmodule
